// ----- hw/rtl/chc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Climate hysteresis controller package
// Shared item and result layouts, key codes, status codes and limits.
// ----------------------------------------------------------------------------
package chc_pkg;

   localparam int ItemDataWidth   = 48;
   localparam int ResultDataWidth = 40;

   // Key codes.
   localparam logic [3:0] KEY_NONE        = 4'd0;
   localparam logic [3:0] KEY_HUM_LOW_DN  = 4'd1;
   localparam logic [3:0] KEY_HUM_LOW_UP  = 4'd2;
   localparam logic [3:0] KEY_HUM_HIGH_DN = 4'd3;
   localparam logic [3:0] KEY_HUM_HIGH_UP = 4'd4;
   localparam logic [3:0] KEY_TMP_LOW_DN  = 4'd5;
   localparam logic [3:0] KEY_TMP_LOW_UP  = 4'd6;
   localparam logic [3:0] KEY_TMP_HIGH_DN = 4'd7;
   localparam logic [3:0] KEY_TMP_HIGH_UP = 4'd8;

   // Operation codes.
   localparam logic OP_READING = 1'b0;
   localparam logic OP_KEY     = 1'b1;

   // Band status codes.
   localparam logic [1:0] STAT_IN_BAND = 2'd0;
   localparam logic [1:0] STAT_ABOVE   = 2'd1;
   localparam logic [1:0] STAT_BELOW   = 2'd2;

   // Threshold reset values and clamps.
   localparam logic signed [7:0] TMP_LOW_RESET  = 8'sd15;
   localparam logic signed [7:0] TMP_HIGH_RESET = 8'sd25;
   localparam logic [6:0]        HUM_LOW_RESET  = 7'd70;
   localparam logic [6:0]        HUM_HIGH_RESET = 7'd75;
   localparam logic signed [7:0] TMP_MIN        = -8'sd20;
   localparam logic signed [7:0] TMP_MAX        = 8'sd80;
   localparam logic [6:0]        HUM_MIN        = 7'd0;
   localparam logic [6:0]        HUM_MAX        = 7'd100;

   // The last member sits in the lowest bits, matching the stream layout.
   typedef struct packed {
      logic        operation;
      logic [3:0]  key_code;
      logic [7:0]  frame_checksum;
      logic [15:0] temperature_raw;
      logic [15:0] humidity_raw;
   } item_type;

   typedef struct packed {
      logic [6:0] hum_high_now;
      logic [6:0] hum_low_now;
      logic [7:0] temp_high_now;
      logic [7:0] temp_low_now;
      logic       reading_valid;
      logic [1:0] hum_status;
      logic [1:0] temp_status;
      logic       fog_on;
      logic       cooler_on;
   } result_type;

endpackage

// ----- hw/rtl/chc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Climate hysteresis controller core
// Holds thresholds, last good reading and drive states; computes one result.
// ----------------------------------------------------------------------------
module chc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  chc_pkg::item_type   item,
   output chc_pkg::result_type result
);

   logic signed [7:0]  temp_low_ff,  temp_low_in;
   logic signed [7:0]  temp_high_ff, temp_high_in;
   logic [6:0]         hum_low_ff,   hum_low_in;
   logic [6:0]         hum_high_ff,  hum_high_in;
   logic signed [15:0] temp_tenths_ff, temp_tenths_in;
   logic [15:0]        hum_tenths_ff,  hum_tenths_in;
   logic               cooler_ff, cooler_in;
   logic               fog_ff,    fog_in;

   logic [7:0]         byte_sum;
   logic               sum_ok;
   logic [15:0]        magnitude;
   logic signed [15:0] temp_hi10, temp_lo10;
   logic [15:0]        hum_hi10, hum_lo10;
   logic [1:0]         temp_stat, hum_stat;

   // Sign-extend a degree value to 16 bits and scale by ten with two shifts.
   function automatic logic signed [15:0] times_ten_s(input logic signed [7:0] v);
      logic signed [15:0] w;
      begin
         w = 16'(v);
         return (w <<< 3) + (w <<< 1);
      end
   endfunction

   function automatic logic [15:0] times_ten_u(input logic [6:0] v);
      logic [15:0] w;
      begin
         w = 16'(v);
         return (w << 3) + (w << 1);
      end
   endfunction

   assign byte_sum = item.humidity_raw[15:8] + item.humidity_raw[7:0]
                   + item.temperature_raw[15:8] + item.temperature_raw[7:0];
   assign sum_ok    = (item.operation == chc_pkg::OP_READING)
                      && (byte_sum == item.frame_checksum);
   assign magnitude = {1'b0, item.temperature_raw[14:0]};

   // Threshold steps; the guards keep each low threshold strictly below its high.
   always_comb begin
      temp_low_in  = temp_low_ff;
      temp_high_in = temp_high_ff;
      hum_low_in   = hum_low_ff;
      hum_high_in  = hum_high_ff;
      if (item.operation == chc_pkg::OP_KEY) begin
         unique case (item.key_code)
            chc_pkg::KEY_HUM_LOW_DN: begin
               if (hum_low_ff > chc_pkg::HUM_MIN) hum_low_in = hum_low_ff - 7'd1;
            end
            chc_pkg::KEY_HUM_LOW_UP: begin
               if (hum_low_ff + 7'd1 < hum_high_ff) hum_low_in = hum_low_ff + 7'd1;
            end
            chc_pkg::KEY_HUM_HIGH_DN: begin
               if (hum_low_ff + 7'd1 < hum_high_ff) hum_high_in = hum_high_ff - 7'd1;
            end
            chc_pkg::KEY_HUM_HIGH_UP: begin
               if (hum_high_ff < chc_pkg::HUM_MAX) hum_high_in = hum_high_ff + 7'd1;
            end
            chc_pkg::KEY_TMP_LOW_DN: begin
               if (temp_low_ff > chc_pkg::TMP_MIN) temp_low_in = temp_low_ff - 8'sd1;
            end
            chc_pkg::KEY_TMP_LOW_UP: begin
               if (temp_low_ff + 8'sd1 < temp_high_ff) temp_low_in = temp_low_ff + 8'sd1;
            end
            chc_pkg::KEY_TMP_HIGH_DN: begin
               if (temp_low_ff + 8'sd1 < temp_high_ff) temp_high_in = temp_high_ff - 8'sd1;
            end
            chc_pkg::KEY_TMP_HIGH_UP: begin
               if (temp_high_ff < chc_pkg::TMP_MAX) temp_high_in = temp_high_ff + 8'sd1;
            end
            default: begin
            end
         endcase
      end
   end

   // A negative zero comes out as zero because the negated magnitude is zero.
   always_comb begin
      temp_tenths_in = temp_tenths_ff;
      hum_tenths_in  = hum_tenths_ff;
      if (sum_ok) begin
         temp_tenths_in = item.temperature_raw[15] ? $signed(16'd0 - magnitude)
                                                   : $signed(magnitude);
         hum_tenths_in  = item.humidity_raw;
      end
   end

   assign temp_hi10 = times_ten_s(temp_high_in);
   assign temp_lo10 = times_ten_s(temp_low_in);
   assign hum_hi10  = times_ten_u(hum_high_in);
   assign hum_lo10  = times_ten_u(hum_low_in);

   always_comb begin
      cooler_in = cooler_ff;
      temp_stat = chc_pkg::STAT_IN_BAND;
      priority if (temp_tenths_in > temp_hi10) begin
         cooler_in = 1'b1;
         temp_stat = chc_pkg::STAT_ABOVE;
      end else if (temp_tenths_in < temp_lo10) begin
         cooler_in = 1'b0;
         temp_stat = chc_pkg::STAT_BELOW;
      end else begin
         // Inside the band the cooler keeps its previous state.
         cooler_in = cooler_ff;
         temp_stat = chc_pkg::STAT_IN_BAND;
      end
   end

   always_comb begin
      fog_in   = fog_ff;
      hum_stat = chc_pkg::STAT_IN_BAND;
      priority if (hum_tenths_in > hum_hi10) begin
         fog_in   = 1'b0;
         hum_stat = chc_pkg::STAT_ABOVE;
      end else if (hum_tenths_in < hum_lo10) begin
         fog_in   = 1'b1;
         hum_stat = chc_pkg::STAT_BELOW;
      end else begin
         fog_in   = fog_ff;
         hum_stat = chc_pkg::STAT_IN_BAND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_low_ff    <= chc_pkg::TMP_LOW_RESET;
         temp_high_ff   <= chc_pkg::TMP_HIGH_RESET;
         hum_low_ff     <= chc_pkg::HUM_LOW_RESET;
         hum_high_ff    <= chc_pkg::HUM_HIGH_RESET;
         temp_tenths_ff <= 16'sd0;
         hum_tenths_ff  <= 16'd0;
         cooler_ff      <= 1'b0;
         fog_ff         <= 1'b0;
      end else if (step) begin
         temp_low_ff    <= temp_low_in;
         temp_high_ff   <= temp_high_in;
         hum_low_ff     <= hum_low_in;
         hum_high_ff    <= hum_high_in;
         temp_tenths_ff <= temp_tenths_in;
         hum_tenths_ff  <= hum_tenths_in;
         cooler_ff      <= cooler_in;
         fog_ff         <= fog_in;
      end
   end

   always_comb begin
      result.cooler_on     = cooler_in;
      result.fog_on        = fog_in;
      result.temp_status   = temp_stat;
      result.hum_status    = hum_stat;
      result.reading_valid = sum_ok;
      result.temp_low_now  = temp_low_in;
      result.temp_high_now = temp_high_in;
      result.hum_low_now   = hum_low_in;
      result.hum_high_now  = hum_high_in;
   end

`ifndef NO_ASSERTIONS
   a_temp_order: assert property (@(posedge clock) disable iff (reset)
      temp_low_ff < temp_high_ff)
      else $error("temperature thresholds out of order");
   a_hum_order: assert property (@(posedge clock) disable iff (reset)
      hum_low_ff < hum_high_ff)
      else $error("humidity thresholds out of order");
   a_clamps: assert property (@(posedge clock) disable iff (reset)
      temp_low_ff >= chc_pkg::TMP_MIN && temp_high_ff <= chc_pkg::TMP_MAX
      && hum_high_ff <= chc_pkg::HUM_MAX)
      else $error("threshold outside its clamp");
`endif

endmodule

// ----- hw/rtl/climate_hysteresis_controller_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Climate hysteresis controller
// Checks sensor frames, adjusts thresholds from keys, drives cooler and fog.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload
//   req_     in         tdata: humidity, temperature, checksum, key; tuser: operation
//   rsp_     out        tdata: drives, status, reading flag, four thresholds
//
// One item per cycle while rsp_ is not stalled; a result is offered on rsp_ after its
// transfer has passed the input register, then the result register.
// Reset is synchronous; it restores default thresholds and turns both drives off.
// A stalled result register holds the input register, which then closes req_tready.
// ----------------------------------------------------------------------------
module climate_hysteresis_controller_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [15:0] humidity_raw, [31:16] temperature_raw, [39:32] frame_checksum,
   // [43:40] key_code, [47:44] zero
   input  logic [chc_pkg::ItemDataWidth-1:0]     req_tdata,
   // [0] operation
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] cooler_on, [1] fog_on, [3:2] temp_status, [5:4] hum_status,
   // [6] reading_valid, [14:7] temp_low_now, [22:15] temp_high_now,
   // [29:23] hum_low_now, [36:30] hum_high_now, [39:37] zero
   output logic [chc_pkg::ResultDataWidth-1:0]   rsp_tdata
);

   logic                in_valid_ff,  in_valid_in;
   chc_pkg::item_type   in_item_ff,   in_item_in;
   logic                out_valid_ff, out_valid_in;
   chc_pkg::result_type out_data_ff,  out_data_in;
   logic                advance;
   chc_pkg::result_type core_result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_item_in  = {req_tuser, req_tdata[$bits(chc_pkg::item_type)-2:0]};
      end
   end

   chc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(chc_pkg::ResultDataWidth - $bits(chc_pkg::result_type))'(0),
                        out_data_ff};

`ifndef NO_ASSERTIONS
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item did not reach the result register");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled input item changed");
   a_key_not_valid: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.operation == chc_pkg::OP_KEY |=> !out_data_ff.reading_valid)
      else $error("key press reported as a valid reading");
`endif

endmodule
